// ----- rtl/scpb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpb_pkg
// Shared types, codes and constants of the servo command packet builder.
// ----------------------------------------------------------------------------
package scpb_pkg;

  // Request operation codes
  typedef enum logic [2:0] {
    OP_RD_POS  = 3'd0,
    OP_RD_LOAD = 3'd1,
    OP_RD_TEMP = 3'd2,
    OP_WR_GOAL = 3'd3,
    OP_WR_LED  = 3'd4
  } op_e;

  localparam logic [7:0] HDR_BYTE     = 8'hFF;
  localparam logic [7:0] INSTR_READ   = 8'd2;
  localparam logic [7:0] INSTR_WRITE  = 8'd3;
  localparam logic [7:0] REG_POSITION = 8'd36;
  localparam logic [7:0] REG_LOAD     = 8'd40;
  localparam logic [7:0] REG_TEMP     = 8'h2B;
  localparam logic [7:0] REG_GOAL     = 8'h1E;
  localparam logic [7:0] REG_LED      = 8'd25;
  localparam logic [7:0] LEN_READ     = 8'd4;
  localparam logic [7:0] LEN_WRITE    = 8'd5;

  // Byte index within a packet: header bytes 0 and 1, body from 2
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned BODY_IDX_W    = 3;
  localparam logic [IDX_W-1:0] IDX_BODY = 4'd2;
  localparam logic [IDX_W-1:0] IDX_LAST_READ  = 4'd7;
  localparam logic [IDX_W-1:0] IDX_LAST_WRITE = 4'd8;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  servo_id;
    logic [15:0] goal_value;
    logic        led_on;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } rsp_t;

  // Classified packet: body bytes (unused tail byte zero), kind, checksum
  typedef struct packed {
    logic [5:0][7:0] body;
    logic            is_write;
    logic [7:0]      checksum;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fq_stat_t;

  typedef struct packed {
    logic out_first;
    logic busy;
  } bk_stat_t;

endpackage
`default_nettype wire

// ----- rtl/scpb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpb_front
// Accepts requests, builds the packet body and checksum, drops bad codes.
// ----------------------------------------------------------------------------
module scpb_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire scpb_pkg::req_t req_i,
  output logic                full_o,
  output logic                desc_valid_o,
  output scpb_pkg::desc_t     desc_o,
  input  wire logic           desc_ready_i
);

  logic            valid_q, valid_d;
  scpb_pkg::desc_t desc_q;
  scpb_pkg::desc_t desc_new;
  logic            op_ok;
  logic            accept;
  logic [7:0]      sum;

  always_comb begin
    desc_new = '0;
    op_ok    = 1'b1;
    desc_new.body[0] = req_i.servo_id;
    case (req_i.operation)
      scpb_pkg::OP_RD_POS: begin
        desc_new.body[1] = scpb_pkg::LEN_READ;
        desc_new.body[2] = scpb_pkg::INSTR_READ;
        desc_new.body[3] = scpb_pkg::REG_POSITION;
        desc_new.body[4] = 8'd2;
      end
      scpb_pkg::OP_RD_LOAD: begin
        desc_new.body[1] = scpb_pkg::LEN_READ;
        desc_new.body[2] = scpb_pkg::INSTR_READ;
        desc_new.body[3] = scpb_pkg::REG_LOAD;
        desc_new.body[4] = 8'd2;
      end
      scpb_pkg::OP_RD_TEMP: begin
        desc_new.body[1] = scpb_pkg::LEN_READ;
        desc_new.body[2] = scpb_pkg::INSTR_READ;
        desc_new.body[3] = scpb_pkg::REG_TEMP;
        desc_new.body[4] = 8'd1;
      end
      scpb_pkg::OP_WR_GOAL: begin
        desc_new.is_write = 1'b1;
        desc_new.body[1]  = scpb_pkg::LEN_WRITE;
        desc_new.body[2]  = scpb_pkg::INSTR_WRITE;
        desc_new.body[3]  = scpb_pkg::REG_GOAL;
        desc_new.body[4]  = req_i.goal_value[7:0];
        desc_new.body[5]  = req_i.goal_value[15:8];
      end
      scpb_pkg::OP_WR_LED: begin
        desc_new.is_write = 1'b1;
        desc_new.body[1]  = scpb_pkg::LEN_WRITE;
        desc_new.body[2]  = scpb_pkg::INSTR_WRITE;
        desc_new.body[3]  = scpb_pkg::REG_LED;
        desc_new.body[4]  = {7'd0, req_i.led_on};
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    // Unused tail byte is zero, so summing all six is safe
    sum = desc_new.body[0] + desc_new.body[1] + desc_new.body[2]
        + desc_new.body[3] + desc_new.body[4] + desc_new.body[5];
    desc_new.checksum = ~sum;
  end

  assign full_o = valid_q && !desc_ready_i;
  assign accept = push_i && !full_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = op_ok;
    end else if (desc_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_new;
    end
  end

  assign desc_valid_o = valid_q;
  assign desc_o       = desc_q;

endmodule
`default_nettype wire

// ----- rtl/scpb_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpb_cmd_fifo
// Two-entry queue of classified packets between front and back.
// ----------------------------------------------------------------------------
module scpb_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire scpb_pkg::desc_t wr_data_i,
  input  wire logic            rd_en_i,
  output scpb_pkg::desc_t      rd_data_o,
  output scpb_pkg::fq_stat_t   stat_o
);

  scpb_pkg::desc_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            do_wr, do_rd;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_wr = wr_en_i && !stat_o.full;
  assign do_rd = rd_en_i && !stat_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ----- rtl/scpb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpb_back
// Serializes one classified packet a byte per cycle into the result register,
// while that register is empty or being popped.
module scpb_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            desc_valid_i,
  input  wire scpb_pkg::desc_t desc_i,
  output logic                 desc_take_o,
  output logic                 empty_o,
  output scpb_pkg::rsp_t       rsp_o,
  input  wire logic            pop_i,
  output scpb_pkg::bk_stat_t   stat_o
);

  scpb_pkg::desc_t              cur_q;
  logic                         cur_valid_q, cur_valid_d;
  logic [scpb_pkg::IDX_W-1:0]   idx_q, idx_d, idx_last, idx_m2;
  scpb_pkg::rsp_t               out_q, out_byte;
  logic                         out_valid_q, out_valid_d;
  logic                         out_first_q;
  logic                         slot_free, emit, at_last;

  assign slot_free = !out_valid_q || pop_i;
  assign emit      = cur_valid_q && slot_free;
  assign idx_last  = cur_q.is_write ? scpb_pkg::IDX_LAST_WRITE : scpb_pkg::IDX_LAST_READ;
  assign at_last   = (idx_q == idx_last);
  assign idx_m2    = idx_q - scpb_pkg::IDX_BODY;
  assign desc_take_o = desc_valid_i && (!cur_valid_q || (emit && at_last));

  always_comb begin
    out_byte.last_byte = at_last;
    if (at_last) begin
      out_byte.tx_byte = cur_q.checksum;
    end else if (idx_q < scpb_pkg::IDX_BODY) begin
      out_byte.tx_byte = scpb_pkg::HDR_BYTE;
    end else begin
      out_byte.tx_byte = cur_q.body[idx_m2[scpb_pkg::BODY_IDX_W-1:0]];
    end
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (emit) begin
      if (at_last) begin
        cur_valid_d = 1'b0;
        idx_d       = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (desc_take_o) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_take_o) begin
      cur_q <= desc_i;
    end
    if (emit) begin
      out_q       <= out_byte;
      out_first_q <= (idx_q == '0);
    end
  end

  assign empty_o          = !out_valid_q;
  assign rsp_o            = out_q;
  assign stat_o.out_first = out_first_q;
  assign stat_o.busy      = cur_valid_q;

endmodule
`default_nettype wire

// ----- rtl/servo_command_packet_builder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_command_packet_builder_core
// Builds servo bus instruction packets from command requests, byte by byte.
// ----------------------------------------------------------------------------
// Push one request per cycle while full_o is low; each valid request yields a
// packet on the result side: two 0xFF header bytes, id, length, instruction,
// register address, parameters and the inverted 8-bit checksum, the last one
// flagged by last_byte. Reads give 8 bytes, writes 9. The back end emits one
// byte per cycle while the result register is empty or being popped, and
// packets follow each other with no gap. Requests with an undefined operation
// code are taken and produce no bytes. A request passes the front register and
// the queue into the serializer before its bytes reach the result register.
// ----------------------------------------------------------------------------
module servo_command_packet_builder_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire scpb_pkg::req_t req_i,
  output logic                full_o,
  output logic                empty_o,
  output scpb_pkg::rsp_t      rsp_o,
  input  wire logic           pop_i
);

  // Front stage to queue
  logic               fe_valid;
  scpb_pkg::desc_t    fe_desc;
  // Queue to back end
  scpb_pkg::desc_t    fq_desc;
  scpb_pkg::fq_stat_t fq_stat;
  logic               bk_take;
  scpb_pkg::bk_stat_t bk_stat;

  // Classify the request and precompute the checksum
  scpb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .req_i        (req_i),
    .full_o       (full_o),
    .desc_valid_o (fe_valid),
    .desc_o       (fe_desc),
    .desc_ready_i (!fq_stat.full)
  );

  // Hold up to two packets so front and back stall independently
  scpb_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fe_valid),
    .wr_data_i (fe_desc),
    .rd_en_i   (bk_take),
    .rd_data_o (fq_desc),
    .stat_o    (fq_stat)
  );

  // Transfer packet bytes to the result register one per cycle while it is free
  scpb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (!fq_stat.empty),
    .desc_i       (fq_desc),
    .desc_take_o  (bk_take),
    .empty_o      (empty_o),
    .rsp_o        (rsp_o),
    .pop_i        (pop_i),
    .stat_o       (bk_stat)
  );

  // The first byte of every packet is a plain header byte
  a_first_is_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && bk_stat.out_first) |->
      (rsp_o.tx_byte == scpb_pkg::HDR_BYTE && !rsp_o.last_byte))
    else $error("packet does not start with a header byte");

  // An undefined operation never reaches the queue
  a_drop_bad_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && req_i.operation > scpb_pkg::OP_WR_LED) |=> !fe_valid)
    else $error("undefined operation was forwarded");

  // The back end takes a packet only from a non-empty queue
  a_take_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_take |-> !fq_stat.empty)
    else $error("back end took from an empty queue");

  // A taken packet keeps the serializer busy on the next cycle
  a_take_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_take |=> bk_stat.busy)
    else $error("serializer idle after taking a packet");

endmodule
`default_nettype wire
